@@ src/ames_pkg.sv @@
package ames_pkg;

	localparam int REQ_W     = 3;
	localparam int VTX_W     = 6;
	localparam int VCNT_W    = 7;
	localparam int WIN_W     = 32;
	localparam int WOUT_W    = 32;
	localparam int ST_W      = 2;
	localparam int NBR_CNT_W = 6;
	localparam int TOTAL_W   = 12;

	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd5;

	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic exec_point;
		logic walk_step;
		logic emit_final;
	} ames_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic walk_go;
		logic is_list;
		logic present;
		logic pend_valid;
		logic walk_end;
		logic out_free;
	} ames_sts_t;

endpackage

@@ src/adjacency_matrix_edge_store.sv @@
// Point requests (add, remove, get, set): a weight RAM read, then the write back and the
// result load; no new request is taken until that result has been loaded.
// List and count walk the row, one row entry read per cycle unless a held neighbour waits on a stalled output.
// Reset and every vertex_count write start a clearing pass that writes no-edge into all
// 4**ceil(log2(MAX_VERTICES)) entries (4096 at 64 vertices); req_stall stays high throughout.
// Reset clears edge total, vertex count and rsp_valid; a vertex_count write zeroes the total.
module adjacency_matrix_edge_store
	import ames_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [VCNT_W-1:0]    cfg_wr_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [VTX_W-1:0]     from_vertex,
	input  logic [VTX_W-1:0]     to_vertex,
	input  logic [WIN_W-1:0]     new_weight,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [ST_W-1:0]      status,
	output logic [WOUT_W-1:0]    weight_out,
	output logic [VTX_W-1:0]     neighbour,
	output logic [NBR_CNT_W-1:0] neighbour_count,
	output logic [TOTAL_W-1:0]   edge_total,
	output logic                 last
);

	ames_cmd_t cmd;
	ames_sts_t sts;

	ames_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cfg_wr_en(cfg_wr_en),
		.sts      (sts),
		.cmd      (cmd)
	);

	ames_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.from_vertex    (from_vertex),
		.to_vertex      (to_vertex),
		.new_weight     (new_weight),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.weight_out     (weight_out),
		.neighbour      (neighbour),
		.neighbour_count(neighbour_count),
		.edge_total     (edge_total),
		.last           (last)
	);

	// no transfer may slip in while the store is being cleared
	assert property (@(posedge clk) disable iff (!arst_n) cmd.clr_step |-> req_stall)
		else $error("request taken during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n) cfg_wr_en |=> req_stall)
		else $error("request taken right after vertex count write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec_point || cmd.emit_final) |-> sts.out_free)
		else $error("result register overwritten while held");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (edge_total <= TOTAL_W'(MAX_VERTICES * (MAX_VERTICES - 1))))
		else $error("edge total beyond matrix capacity");

endmodule

@@ src/ames_ram.sv @@
module ames_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/ames_ctrl.sv @@
module ames_ctrl
	import ames_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  logic      cfg_wr_en,
	input  ames_sts_t sts,
	output ames_cmd_t cmd
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       walk_hold;

	// a new neighbour pushes out the held one, which needs a free output slot
	assign walk_hold = sts.is_list & sts.present & sts.pend_valid & ~sts.out_free;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = cfg_wr_en;
				if (req_valid && !cfg_wr_en) begin
					cmd.accept = 1'b1;
					state_nxt  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.walk_go) begin
					state_nxt = S_WALK;
				end else if (sts.out_free) begin
					cmd.exec_point = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			S_WALK: begin
				if (!walk_hold) begin
					cmd.walk_step = 1'b1;
					if (sts.walk_end) begin
						state_nxt = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLR;
			end
		endcase
		if (cfg_wr_en) begin
			state_nxt = S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ src/ames_dp.sv @@
module ames_dp
	import ames_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [VCNT_W-1:0]    cfg_wr_data,
	input  ames_cmd_t            cmd,
	output ames_sts_t            sts,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [VTX_W-1:0]     from_vertex,
	input  logic [VTX_W-1:0]     to_vertex,
	input  logic [WIN_W-1:0]     new_weight,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [ST_W-1:0]      status,
	output logic [WOUT_W-1:0]    weight_out,
	output logic [VTX_W-1:0]     neighbour,
	output logic [NBR_CNT_W-1:0] neighbour_count,
	output logic [TOTAL_W-1:0]   edge_total,
	output logic                 last
);

	localparam int VB    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VB;
	localparam int DEPTH = 1 << AW;
	localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;
	localparam logic [VCNT_W-1:0] VC_MAX = VCNT_W'(MAX_VERTICES);

	// configuration and bookkeeping
	logic [VCNT_W-1:0]    vc_q;
	logic [AW-1:0]        clr_q;
	logic [TOTAL_W-1:0]   total_q;

	// captured request
	logic [REQ_W-1:0]     req_q;
	logic [VTX_W-1:0]     a_q;
	logic [VTX_W-1:0]     b_q;
	logic [WEIGHT_BITS-1:0] w_q;

	// row walk
	logic [VB-1:0]        col_q;
	logic [NBR_CNT_W-1:0] cnt_q;
	logic                 pend_valid_q;
	logic [WOUT_W-1:0]    pend_w_q;
	logic [VB-1:0]        pend_col_q;

	// result register
	logic                 rsp_valid_q;
	logic [ST_W-1:0]      status_q;
	logic [WOUT_W-1:0]    weight_q;
	logic [VTX_W-1:0]     nbr_q;
	logic [NBR_CNT_W-1:0] nbr_cnt_q;
	logic [TOTAL_W-1:0]   total_out_q;
	logic                 last_q;

	// memory port
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [WEIGHT_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [AW-1:0]          acc_addr;
	logic [WEIGHT_BITS-1:0] rd_data;
	logic [63:0]            rd_ext;
	logic [63:0]            nw_ext;

	logic                   a_ok;
	logic                   b_ok;
	logic                   pair_ok;
	logic                   rd_empty;
	logic                   present;
	logic                   w_bad;
	logic                   col_last;
	logic                   is_list;
	logic                   is_walk;
	logic                   out_free;
	logic                   walk_emit;
	logic                   load;

	logic [ST_W-1:0]        pt_status;
	logic                   pt_wr;
	logic [WEIGHT_BITS-1:0] pt_wdata;
	logic [WOUT_W-1:0]      pt_weight;
	logic [TOTAL_W-1:0]     pt_total;

	logic [ST_W-1:0]        ld_status;
	logic [WOUT_W-1:0]      ld_weight;
	logic [VTX_W-1:0]       ld_nbr;
	logic [NBR_CNT_W-1:0]   ld_cnt;
	logic [TOTAL_W-1:0]     ld_total;
	logic                   ld_last;

	assign rd_ext   = 64'(rd_data);
	assign nw_ext   = 64'(new_weight);

	assign a_ok     = {1'b0, a_q} < vc_q;
	assign b_ok     = {1'b0, b_q} < vc_q;
	assign pair_ok  = a_ok & b_ok;
	assign rd_empty = (rd_data == NO_EDGE);
	assign present  = pair_ok & ~rd_empty;
	assign w_bad    = (w_q == NO_EDGE);
	assign col_last = (VCNT_W'(col_q) == vc_q - VCNT_W'(1));
	assign is_list  = (req_q == REQ_LIST);
	assign is_walk  = is_list | (req_q == REQ_COUNT);
	assign out_free = ~rsp_valid_q | ~rsp_stall;

	// list and count start at column 0 of the row
	assign acc_addr = (req_type == REQ_LIST || req_type == REQ_COUNT)
		? {from_vertex[VB-1:0], VB'(0)}
		: {from_vertex[VB-1:0], to_vertex[VB-1:0]};

	always_comb begin
		pt_status = ST_REFUSED;
		pt_wr     = 1'b0;
		pt_wdata  = w_q;
		pt_weight = '0;
		pt_total  = total_q;
		unique case (req_q)
			REQ_ADD: begin
				if (pair_ok && a_q != b_q && rd_empty && !w_bad) begin
					pt_status = ST_DONE;
					pt_wr     = 1'b1;
					pt_total  = total_q + TOTAL_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (present) begin
					pt_status = ST_DONE;
					pt_wr     = 1'b1;
					pt_wdata  = NO_EDGE;
					pt_total  = total_q - TOTAL_W'(1);
				end
			end
			REQ_GET: begin
				if (present) begin
					pt_status = ST_DONE;
					pt_weight = rd_ext[WOUT_W-1:0];
				end
			end
			REQ_SET: begin
				if (present && !w_bad) begin
					pt_status = ST_DONE;
					pt_wr     = 1'b1;
				end
			end
			default: begin
				pt_status = ST_REFUSED;
			end
		endcase
	end

	assign ram_we    = cmd.clr_step | (cmd.exec_point & pt_wr);
	assign ram_waddr = cmd.clr_step ? clr_q : {a_q[VB-1:0], b_q[VB-1:0]};
	assign ram_wdata = cmd.clr_step ? NO_EDGE : pt_wdata;
	assign ram_re    = cmd.accept | (cmd.walk_step & ~col_last);
	assign ram_raddr = cmd.accept ? acc_addr : {a_q[VB-1:0], col_q + VB'(1)};

	ames_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(rd_data)
	);

	assign walk_emit = cmd.walk_step & is_list & ~rd_empty & pend_valid_q;
	assign load      = cmd.exec_point | cmd.emit_final | walk_emit;

	always_comb begin
		ld_status = pt_status;
		ld_weight = pt_weight;
		ld_nbr    = '0;
		ld_cnt    = '0;
		ld_total  = pt_total;
		ld_last   = 1'b1;
		priority if (walk_emit) begin
			ld_status = ST_DONE;
			ld_weight = pend_w_q;
			ld_nbr    = VTX_W'(pend_col_q);
			ld_total  = total_q;
			ld_last   = 1'b0;
		end else if (cmd.emit_final) begin
			ld_total = total_q;
			if (!is_list) begin
				ld_status = ST_DONE;
				ld_weight = '0;
				ld_cnt    = cnt_q;
			end else if (pend_valid_q) begin
				ld_status = ST_DONE;
				ld_weight = pend_w_q;
				ld_nbr    = VTX_W'(pend_col_q);
			end else begin
				ld_status = ST_EMPTY;
				ld_weight = '0;
			end
		end else begin
			ld_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q         <= '0;
			clr_q        <= '0;
			total_q      <= '0;
			col_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vc_q    <= (cfg_wr_data > VC_MAX) ? VC_MAX : cfg_wr_data;
				clr_q   <= '0;
				total_q <= '0;
			end else begin
				if (cmd.clr_step) begin
					clr_q <= clr_q + AW'(1);
				end
				if (cmd.exec_point) begin
					total_q <= pt_total;
				end
			end
			if (cmd.accept) begin
				col_q        <= '0;
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.walk_step) begin
				col_q <= col_q + VB'(1);
				if (!rd_empty) begin
					cnt_q <= cnt_q + NBR_CNT_W'(1);
					if (is_list) begin
						pend_valid_q <= 1'b1;
					end
				end
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			a_q   <= from_vertex;
			b_q   <= to_vertex;
			w_q   <= nw_ext[WEIGHT_BITS-1:0];
		end
		if (cmd.walk_step && !rd_empty) begin
			pend_w_q   <= rd_ext[WOUT_W-1:0];
			pend_col_q <= col_q;
		end
		if (load) begin
			status_q    <= ld_status;
			weight_q    <= ld_weight;
			nbr_q       <= ld_nbr;
			nbr_cnt_q   <= ld_cnt;
			total_out_q <= ld_total;
			last_q      <= ld_last;
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_last   = &clr_q;
		sts.walk_go    = is_walk & a_ok;
		sts.is_list    = is_list;
		sts.present    = ~rd_empty;
		sts.pend_valid = pend_valid_q;
		sts.walk_end   = col_last;
		sts.out_free   = out_free;
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign weight_out      = weight_q;
	assign neighbour       = nbr_q;
	assign neighbour_count = nbr_cnt_q;
	assign edge_total      = total_out_q;
	assign last            = last_q;

endmodule

@@ tb/edge_store_checker.sv @@
`timescale 1ns / 1ps

module edge_store_checker
	import ames_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [VCNT_W-1:0]    cfg_wr_data,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [VTX_W-1:0]     from_vertex,
	input  logic [VTX_W-1:0]     to_vertex,
	input  logic [WIN_W-1:0]     new_weight,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  logic [ST_W-1:0]      status,
	input  logic [WOUT_W-1:0]    weight_out,
	input  logic [VTX_W-1:0]     neighbour,
	input  logic [NBR_CNT_W-1:0] neighbour_count,
	input  logic [TOTAL_W-1:0]   edge_total,
	input  logic                 last,
	output int unsigned          mismatches,
	output int unsigned          pending,
	output int unsigned          results_checked,
	output int unsigned          longest_list
);

	localparam int VERTS = 64;
	localparam logic [WOUT_W-1:0] NO_EDGE = '1;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [WOUT_W-1:0]    weight;
		logic [VTX_W-1:0]     nbr;
		logic [NBR_CNT_W-1:0] cnt;
		logic [TOTAL_W-1:0]   total;
		logic                 last;
	} edge_result_t;

	// row-major: index {from, to}
	logic [WOUT_W-1:0] edge_weights [0:VERTS*VERTS-1];
	int unsigned       edge_count;
	int unsigned       vertices_in_use;
	edge_result_t      expected_results [$];
	edge_result_t      want;

	function automatic void clear_store();
		int i;
		for (i = 0; i < VERTS * VERTS; i++)
			edge_weights[i] = NO_EDGE;
		edge_count = 0;
	endfunction

	function automatic void expect_result(logic [ST_W-1:0] st, logic [WOUT_W-1:0] w,
			logic [VTX_W-1:0] nb, logic [NBR_CNT_W-1:0] cnt, logic lst);
		edge_result_t r;
		r.status = st;
		r.weight = w;
		r.nbr    = nb;
		r.cnt    = cnt;
		r.total  = edge_count[TOTAL_W-1:0];
		r.last   = lst;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void predict_request(logic [REQ_W-1:0] rt, logic [VTX_W-1:0] a,
			logic [VTX_W-1:0] b, logic [WIN_W-1:0] w);
		logic            pair_ok;
		logic            present;
		logic [11:0]     idx;
		int              last_col;
		int unsigned     n;
		int              c;
		pair_ok = (a < vertices_in_use) && (b < vertices_in_use);
		idx     = {a, b};
		present = pair_ok && (edge_weights[idx] != NO_EDGE);
		case (rt)
			REQ_ADD: begin
				if (!pair_ok || a == b || present || w == NO_EDGE) begin
					expect_result(ST_REFUSED, '0, '0, '0, 1'b1);
				end else begin
					edge_weights[idx] = w;
					edge_count++;
					expect_result(ST_DONE, '0, '0, '0, 1'b1);
				end
			end
			REQ_REMOVE: begin
				if (!present) begin
					expect_result(ST_REFUSED, '0, '0, '0, 1'b1);
				end else begin
					edge_weights[idx] = NO_EDGE;
					edge_count--;
					expect_result(ST_DONE, '0, '0, '0, 1'b1);
				end
			end
			REQ_GET: begin
				if (!present)
					expect_result(ST_REFUSED, '0, '0, '0, 1'b1);
				else
					expect_result(ST_DONE, edge_weights[idx], '0, '0, 1'b1);
			end
			REQ_SET: begin
				if (!present || w == NO_EDGE) begin
					expect_result(ST_REFUSED, '0, '0, '0, 1'b1);
				end else begin
					edge_weights[idx] = w;
					expect_result(ST_DONE, '0, '0, '0, 1'b1);
				end
			end
			REQ_LIST, REQ_COUNT: begin
				if (a >= vertices_in_use) begin
					expect_result(ST_REFUSED, '0, '0, '0, 1'b1);
				end else begin
					last_col = -1;
					n = 0;
					for (c = 0; c < vertices_in_use; c++)
						if (edge_weights[{a, c[VTX_W-1:0]}] != NO_EDGE) begin
							last_col = c;
							n++;
						end
					if (rt == REQ_COUNT) begin
						expect_result(ST_DONE, '0, '0, n[NBR_CNT_W-1:0], 1'b1);
					end else if (last_col < 0) begin
						expect_result(ST_EMPTY, '0, '0, '0, 1'b1);
					end else begin
						for (c = 0; c <= last_col; c++)
							if (edge_weights[{a, c[VTX_W-1:0]}] != NO_EDGE)
								expect_result(ST_DONE, edge_weights[{a, c[VTX_W-1:0]}],
									c[VTX_W-1:0], '0, c == last_col);
						if (n > longest_list)
							longest_list = n;
					end
				end
			end
			default: expect_result(ST_REFUSED, '0, '0, '0, 1'b1);
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_store();
			vertices_in_use = 0;
			expected_results.delete();
			mismatches      = 0;
			pending         = 0;
			results_checked = 0;
			longest_list    = 0;
		end else begin
			// older expectations first; a result never belongs to a request taken this edge
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: status %0d total %0d",
						status, edge_total);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, status);
					check_field("weight_out", want.weight, weight_out);
					check_field("neighbour", want.nbr, neighbour);
					check_field("neighbour_count", want.cnt, neighbour_count);
					check_field("edge_total", want.total, edge_total);
					check_field("last", want.last, last);
					results_checked++;
				end
			end
			if (cfg_wr_en) begin
				vertices_in_use = (cfg_wr_data > VERTS) ? VERTS : cfg_wr_data;
				clear_store();
			end
			if (req_valid && !req_stall)
				predict_request(req_type, from_vertex, to_vertex, new_weight);
			pending = expected_results.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb
	import ames_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 400;
	localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;
	localparam logic [WIN_W-1:0] NO_EDGE    = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [VCNT_W-1:0]    cfg_wr_data;
	logic                 req_valid;
	logic                 req_stall;
	logic [REQ_W-1:0]     req_type;
	logic [VTX_W-1:0]     from_vertex;
	logic [VTX_W-1:0]     to_vertex;
	logic [WIN_W-1:0]     new_weight;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [ST_W-1:0]      status;
	logic [WOUT_W-1:0]    weight_out;
	logic [VTX_W-1:0]     neighbour;
	logic [NBR_CNT_W-1:0] neighbour_count;
	logic [TOTAL_W-1:0]   edge_total;
	logic                 last;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned results_checked;
	int unsigned longest_list;
	int unsigned requests_sent;
	int unsigned burst_left;
	int unsigned quiet_cycles;
	bit          long_hold_req;
	logic [11:0] added_pairs [$];

	adjacency_matrix_edge_store dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.new_weight      (new_weight),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.weight_out      (weight_out),
		.neighbour       (neighbour),
		.neighbour_count (neighbour_count),
		.edge_total      (edge_total),
		.last            (last)
	);

	edge_store_checker store_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.new_weight      (new_weight),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.weight_out      (weight_out),
		.neighbour       (neighbour),
		.neighbour_count (neighbour_count),
		.edge_total      (edge_total),
		.last            (last),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.longest_list    (longest_list)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: windows of no / light / heavy stall, plus one long hold-off on request
	initial begin : rsp_side
		int unsigned window;
		int unsigned mode;
		bit          hold_taken;
		rsp_stall  = 1'b0;
		window     = 0;
		mode       = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				rsp_stall  = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (window == 0) begin
				window = $urandom_range(20, 120);
				mode   = $urandom_range(0, 2);
			end
			window--;
			case (mode)
				0: rsp_stall = 1'b0;
				1: rsp_stall = ($urandom_range(0, 3) == 0);
				default: rsp_stall = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("adjacency_matrix_edge_store verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [VTX_W-1:0] pick_vertex(int unsigned vc);
		if (vc == 0 || $urandom_range(0, 9) == 0)
			return VTX_W'($urandom_range(0, 63));
		return VTX_W'($urandom_range(0, vc - 1));
	endfunction

	function automatic logic [WIN_W-1:0] pick_weight();
		case ($urandom_range(0, 15))
			0: return NO_EDGE;
			1: return '0;
			2: return NO_EDGE - 1;
			default: return $urandom;
		endcase
	endfunction

	task automatic idle_for(input int unsigned n);
		if (n == 0)
			return;
		@(negedge clk);
		req_valid   = 1'b0;
		req_type    = $urandom;
		from_vertex = $urandom;
		to_vertex   = $urandom;
		new_weight  = $urandom;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_request(input logic [REQ_W-1:0] rt, input logic [VTX_W-1:0] a,
			input logic [VTX_W-1:0] b, input logic [WIN_W-1:0] w);
		@(negedge clk);
		req_valid   = 1'b1;
		req_type    = rt;
		from_vertex = a;
		to_vertex   = b;
		new_weight  = w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		requests_sent++;
		if (rt == REQ_ADD)
			added_pairs.insert(added_pairs.size(), {a, b});
	endtask

	// bursts of random length separated by random gaps
	task automatic offer(input logic [REQ_W-1:0] rt, input logic [VTX_W-1:0] a,
			input logic [VTX_W-1:0] b, input logic [WIN_W-1:0] w);
		int unsigned r;
		if (burst_left == 0) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				idle_for(0);
			else if (r < 9)
				idle_for($urandom_range(1, 6));
			else
				idle_for($urandom_range(15, 40));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_request(rt, a, b, w);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_vertex_count(input logic [VCNT_W-1:0] v);
		settle();
		// covers the clearing pass after reset or a previous write
		while (req_stall)
			@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		added_pairs.delete();
	endtask

	// mostly requests on live vertices and on edges added earlier, some noise
	task automatic random_requests(input int unsigned count, input int unsigned vc);
		int unsigned          i;
		int unsigned          r;
		logic [REQ_W-1:0]     rt;
		logic [VTX_W-1:0]     a;
		logic [VTX_W-1:0]     b;
		logic [WIN_W-1:0]     w;
		logic [11:0]          pair;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			a = pick_vertex(vc);
			b = pick_vertex(vc);
			w = pick_weight();
			if (added_pairs.size() != 0 && $urandom_range(0, 3) != 0)
				pair = added_pairs[$urandom_range(0, added_pairs.size() - 1)];
			else
				pair = {a, b};
			if (r < 35) begin
				rt = REQ_ADD;
				if ($urandom_range(0, 9) == 0)
					b = a;
			end else if (r < 48) begin
				rt = REQ_REMOVE;
				{a, b} = pair;
			end else if (r < 63) begin
				rt = REQ_GET;
				{a, b} = pair;
			end else if (r < 73) begin
				rt = REQ_SET;
				{a, b} = pair;
			end else if (r < 84) begin
				rt = REQ_LIST;
				a = pair[11:6];
			end else if (r < 95) begin
				rt = REQ_COUNT;
				a = pair[11:6];
			end else begin
				rt = $urandom_range(0, 1) ? REQ_RSVD_A : REQ_RSVD_B;
			end
			offer(rt, a, b, w);
		end
	endtask

	initial begin : stimulus
		int unsigned      c;
		int unsigned      mid_count;
		logic [VTX_W-1:0] row;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		req_valid     = 1'b0;
		req_type      = '0;
		from_vertex   = '0;
		to_vertex     = '0;
		new_weight    = '0;
		burst_left    = 0;
		requests_sent = 0;
		long_hold_req = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// oversized count saturates to the full 64
		write_vertex_count(7'd127);
		offer(REQ_ADD, 6'd0, 6'd63, 32'h0000_0000);
		offer(REQ_ADD, 6'd63, 6'd0, 32'hFFFF_FFFE);
		offer(REQ_ADD, 6'd42, 6'd21, 32'hA5A5_5A5A);
		offer(REQ_ADD, 6'd5, 6'd5, 32'h0000_0001);
		offer(REQ_ADD, 6'd0, 6'd63, 32'h0000_0002);
		offer(REQ_ADD, 6'd1, 6'd2, NO_EDGE);
		offer(REQ_GET, 6'd0, 6'd63, 32'h0);
		offer(REQ_GET, 6'd63, 6'd0, 32'h0);
		offer(REQ_GET, 6'd1, 6'd2, 32'h0);
		offer(REQ_SET, 6'd0, 6'd63, NO_EDGE);
		offer(REQ_SET, 6'd0, 6'd63, 32'h1234_5678);
		offer(REQ_SET, 6'd7, 6'd8, 32'h0000_0009);
		offer(REQ_LIST, 6'd0, 6'd0, 32'h0);
		offer(REQ_ADD, 6'd0, 6'd1, 32'h0000_0007);
		offer(REQ_LIST, 6'd0, 6'd0, 32'h0);
		offer(REQ_LIST, 6'd9, 6'd0, 32'h0);
		offer(REQ_COUNT, 6'd0, 6'd0, 32'h0);
		offer(REQ_COUNT, 6'd9, 6'd0, 32'h0);
		offer(REQ_REMOVE, 6'd0, 6'd63, 32'h0);
		offer(REQ_REMOVE, 6'd0, 6'd63, 32'h0);
		offer(REQ_RSVD_A, 6'd3, 6'd4, 32'h0);
		offer(REQ_RSVD_B, 6'd3, 6'd4, 32'h0);

		// no vertices at all
		write_vertex_count(7'd0);
		offer(REQ_ADD, 6'd0, 6'd1, 32'h0000_0003);
		offer(REQ_LIST, 6'd0, 6'd0, 32'h0);
		offer(REQ_COUNT, 6'd0, 6'd0, 32'h0);

		write_vertex_count(7'd3);
		offer(REQ_ADD, 6'd0, 6'd5, 32'h0000_0004);
		offer(REQ_LIST, 6'd5, 6'd0, 32'h0);
		offer(REQ_COUNT, 6'd5, 6'd0, 32'h0);
		random_requests(80, 3);

		write_vertex_count(7'd2);
		random_requests(60, 2);

		// receiver holds off while requests keep coming; start it once the clear is over
		write_vertex_count(7'd5);
		while (req_stall)
			@(negedge clk);
		long_hold_req = 1'b1;
		random_requests(80, 5);

		// one full row: a list of 63 neighbours
		write_vertex_count(7'd64);
		row = VTX_W'($urandom_range(0, 63));
		for (c = 0; c < 64; c++)
			offer(REQ_ADD, row, VTX_W'(c), $urandom_range(0, 32'hFFFF_FFFE));
		offer(REQ_LIST, row, 6'd0, 32'h0);
		offer(REQ_COUNT, row, 6'd0, 32'h0);
		random_requests(30, 64);
		settle();
		random_requests(30, 64);

		mid_count = $urandom_range(6, 63);
		write_vertex_count(VCNT_W'(mid_count));
		random_requests(70, mid_count);

		write_vertex_count(7'd1);
		random_requests(10, 1);

		settle();
		repeat (20) @(negedge clk);
		$display("%0d requests, %0d results checked; vertex counts 0, 1, 2, 3, 5, %0d and 64",
			requests_sent, results_checked, mid_count);
		$display("longest neighbour list %0d, one long response hold-off, one mid-run drain",
			longest_list);
		if (mismatches == 0)
			$display("adjacency_matrix_edge_store verification clean");
		else
			$display("adjacency_matrix_edge_store verification failed");
		$finish;
	end

endmodule
